// File: hdl/sbdn_pkg.sv
`default_nettype none

package sbdn_pkg;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_DB    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_DB    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_LOG2 = 2'd2;

  localparam logic signed [15:0] MIN_DB_RST    = -16'sd25600;
  localparam logic signed [15:0] MAX_DB_RST    = 16'sd0;
  localparam logic [4:0]         SIZE_LOG2_RST = 5'd10;

  // Step counts of the iterative units.
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 16;
  localparam int HORNER_STEPS = 3;

  // Cubic log2 polynomial on the mantissa, Q30.
  localparam logic signed [35:0] COEF3 = 36'sd1322308669;
  localparam logic signed [35:0] COEF2 = -36'sd4422232720;
  localparam logic signed [35:0] COEF1 = 36'sd6466041204;
  localparam logic signed [35:0] COEF0 = -36'sd3365068760;

  // 20*log10(2) in Q24.
  localparam logic signed [27:0] DB_PER_LOG2 = 28'sd101008905;

  // Half-up rounding offsets for shifts by 30 and 46.
  localparam logic signed [67:0] RND_Q30 = 68'sd536870912;
  localparam logic signed [67:0] RND_Q46 = 68'sd35184372088832;

  // How the final level is formed.
  localparam logic [1:0] LVL_QUOT = 2'd0;
  localparam logic [1:0] LVL_ZERO = 2'd1;
  localparam logic [1:0] LVL_FULL = 2'd2;

  typedef struct packed {
    logic              is_zero;
    logic signed [6:0] expo;
  } sq_side_t;

  typedef struct packed {
    logic              is_zero;
    logic signed [6:0] expo;
    logic [29:0]       f;
  } hz_tag_t;

  typedef struct packed {
    logic [1:0] sel;
  } div_side_t;

  // Coefficient added after the multiply of Horner step idx.
  function automatic logic signed [35:0] horner_coef(input logic [1:0] idx);
    logic signed [35:0] c;
    unique case (idx)
      2'd0:    c = COEF2;
      2'd1:    c = COEF1;
      default: c = COEF0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sbdn_ifs.sv
`default_nettype none

interface sbdn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] bin_re;
  logic signed [31:0] bin_im;

  modport source (output valid, output bin_re, output bin_im, input ready);
  modport sink   (input valid, input bin_re, input bin_im, output ready);
endinterface

interface sbdn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

`default_nettype wire

// File: hdl/sbdn_isqrt.sv
`default_nettype none

// Pipelined integer square root, one result bit per stage.
module sbdn_isqrt (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic [63:0]         in_rad,
  input  wire sbdn_pkg::sq_side_t  in_side,
  output logic                     out_vld,
  output logic [31:0]              out_root,
  output sbdn_pkg::sq_side_t       out_side
);

  logic               vld_r  [sbdn_pkg::SQRT_STEPS];
  logic [33:0]        rem_r  [sbdn_pkg::SQRT_STEPS];
  logic [31:0]        root_r [sbdn_pkg::SQRT_STEPS];
  logic [63:0]        rad_r  [sbdn_pkg::SQRT_STEPS];
  sbdn_pkg::sq_side_t side_r [sbdn_pkg::SQRT_STEPS];

  for (genvar k = 0; k < sbdn_pkg::SQRT_STEPS; k++) begin : g_step
    logic               vld_p;
    logic [33:0]        rem_p;
    logic [31:0]        root_p;
    logic [63:0]        rad_p;
    sbdn_pkg::sq_side_t side_p;
    logic [35:0]        cur;
    logic [35:0]        trial;
    logic [35:0]        diff;
    logic               ge;

    if (k == 0) begin : g_head
      assign vld_p  = in_vld;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = in_rad;
      assign side_p = in_side;
    end else begin : g_body
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign side_p = side_r[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      cur   = {rem_p, rad_p[63:62]};
      trial = {2'b00, root_p, 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[33:0] : cur[33:0];
        root_r[k] <= {root_p[30:0], ge};
        rad_r[k]  <= {rad_p[61:0], 2'b00};
        side_r[k] <= side_p;
      end
    end
  end

  assign out_vld  = vld_r[sbdn_pkg::SQRT_STEPS-1];
  assign out_root = root_r[sbdn_pkg::SQRT_STEPS-1];
  assign out_side = side_r[sbdn_pkg::SQRT_STEPS-1];

endmodule

`default_nettype wire

// File: hdl/sbdn_div.sv
`default_nettype none

// Pipelined restoring divider for a 32-bit dividend whose quotient fits in
// 16 bits, one quotient bit per stage.
module sbdn_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic [31:0]         in_num,
  input  wire logic [15:0]         in_den,
  input  wire sbdn_pkg::div_side_t in_side,
  output logic                     out_vld,
  output logic [15:0]              out_quot,
  output sbdn_pkg::div_side_t      out_side
);

  logic                vld_r  [sbdn_pkg::DIV_STEPS];
  logic [15:0]         rem_r  [sbdn_pkg::DIV_STEPS];
  logic [15:0]         lo_r   [sbdn_pkg::DIV_STEPS];
  logic [15:0]         quot_r [sbdn_pkg::DIV_STEPS];
  logic [15:0]         den_r  [sbdn_pkg::DIV_STEPS];
  sbdn_pkg::div_side_t side_r [sbdn_pkg::DIV_STEPS];

  for (genvar k = 0; k < sbdn_pkg::DIV_STEPS; k++) begin : g_step
    logic                vld_p;
    logic [15:0]         rem_p;
    logic [15:0]         lo_p;
    logic [15:0]         quot_p;
    logic [15:0]         den_p;
    sbdn_pkg::div_side_t side_p;
    logic [16:0]         cur;
    logic [16:0]         diff;
    logic                ge;

    if (k == 0) begin : g_head
      assign vld_p  = in_vld;
      assign rem_p  = in_num[31:16];
      assign lo_p   = in_num[15:0];
      assign quot_p = '0;
      assign den_p  = in_den;
      assign side_p = in_side;
    end else begin : g_body
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign lo_p   = lo_r[k-1];
      assign quot_p = quot_r[k-1];
      assign den_p  = den_r[k-1];
      assign side_p = side_r[k-1];
    end

    always_comb begin
      cur  = {rem_p, lo_p[15]};
      diff = cur - {1'b0, den_p};
      ge   = (cur >= {1'b0, den_p});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[15:0] : cur[15:0];
        lo_r[k]   <= {lo_p[14:0], 1'b0};
        quot_r[k] <= {quot_p[14:0], ge};
        den_r[k]  <= den_p;
        side_r[k] <= side_p;
      end
    end
  end

  assign out_vld  = vld_r[sbdn_pkg::DIV_STEPS-1];
  assign out_quot = quot_r[sbdn_pkg::DIV_STEPS-1];
  assign out_side = side_r[sbdn_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

// File: hdl/spectrum_bin_db_normalizer_top.sv
// Throughput: one item per clock; the pipeline is 68 stages deep, chiefly the 32-stage
// square root and the 16-stage divider, plus an output register with a one-item skid.
// A full skid stage freezes the whole pipeline until it drains, nothing is dropped.
// Reset (synchronous, rst_n low) clears all valid bits and loads the register defaults:
// min_db = -100 dB, max_db = 0 dB, size_log2 = 10.
`default_nettype none

module spectrum_bin_db_normalizer_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  sbdn_in_if.sink                              in_ch,
  sbdn_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [sbdn_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [sbdn_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must see that they are written only while the
  // pipeline is empty, so every stage may read them directly; nothing enforces it.
  // ---------------------------------------------------------------------------
  logic signed [15:0] min_db_r;
  logic signed [15:0] max_db_r;
  logic [4:0]         size_log2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_db_r    <= sbdn_pkg::MIN_DB_RST;
      max_db_r    <= sbdn_pkg::MAX_DB_RST;
      size_log2_r <= sbdn_pkg::SIZE_LOG2_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sbdn_pkg::REG_MIN_DB:    min_db_r    <= $signed(cfg_wdata);
        sbdn_pkg::REG_MAX_DB:    max_db_r    <= $signed(cfg_wdata);
        sbdn_pkg::REG_SIZE_LOG2: size_log2_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global pipeline enable. All stages advance together unless the skid stage
  // holds an item; that flag is a register, so in_ch.ready has no combinational
  // path from out_ch.ready.
  // ---------------------------------------------------------------------------
  logic skid_vld_r;
  logic en;

  assign en          = !skid_vld_r;
  assign in_ch.ready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: absolute values. The most negative input gives 2^31, which still
  // fits in 32 unsigned bits.
  // Stage 2: squares, each a 32x32 multiply.
  // Stage 3: power p = re^2 + im^2, exact in 64 bits.
  // ---------------------------------------------------------------------------
  logic        v1_r, v2_r, v3_r;
  logic [31:0] ar_r, ai_r;
  logic [63:0] sq_re_r, sq_im_r;
  logic [63:0] p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ar_r    <= in_ch.bin_re[31] ? (32'd0 - in_ch.bin_re) : in_ch.bin_re;
      ai_r    <= in_ch.bin_im[31] ? (32'd0 - in_ch.bin_im) : in_ch.bin_im;
      sq_re_r <= ar_r * ar_r;
      sq_im_r <= ai_r * ai_r;
      p3_r    <= sq_re_r + sq_im_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4 and 5: count leading zero bit pairs of p. The normalizing shift is
  // even so that the root of the shifted value is the root of p scaled by a
  // power of two. Stage 4 counts within four 16-bit blocks, stage 5 picks the
  // first nonzero block and forms the exponent
  //   expo = 32 - shift/2 - size_log2,
  // which also folds in the division by the transform size.
  // Stage 6: the normalizing shift itself.
  // ---------------------------------------------------------------------------
  function automatic logic [3:0] lead_pairs(input logic [15:0] x);
    logic [3:0] cnt;
    logic       found;
    cnt   = 4'd8;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && (x[2*i +: 2] != 2'b00)) begin
        cnt   = 4'(7 - i);
        found = 1'b1;
      end
    end
    return cnt;
  endfunction

  logic               v4_r, v5_r, v6_r;
  logic [63:0]        p4_r, p5_r;
  logic [3:0]         lp_r [4];
  logic [4:0]         hs5_r;
  sbdn_pkg::sq_side_t side5_r, side6_r;
  logic [63:0]        rad6_r;

  logic [4:0]         half_s;
  logic               p_zero;
  logic [6:0]         expo_nxt;

  always_comb begin
    p_zero = lp_r[0][3] & lp_r[1][3] & lp_r[2][3] & lp_r[3][3];
    priority if (!lp_r[0][3]) begin
      half_s = {2'b00, lp_r[0][2:0]};
    end else if (!lp_r[1][3]) begin
      half_s = {2'b01, lp_r[1][2:0]};
    end else if (!lp_r[2][3]) begin
      half_s = {2'b10, lp_r[2][2:0]};
    end else begin
      half_s = {2'b11, lp_r[3][2:0]};
    end
    expo_nxt = 7'd32 - {2'b00, half_s} - {2'b00, size_log2_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < 4; b++) begin
        lp_r[b] <= lead_pairs(p3_r[63-16*b -: 16]);
      end
      p4_r            <= p3_r;
      p5_r            <= p4_r;
      hs5_r           <= half_s;
      side5_r.is_zero <= p_zero;
      side5_r.expo    <= $signed(expo_nxt);
      rad6_r          <= p5_r << {hs5_r, 1'b0};
      side6_r         <= side5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 7 to 38: square root of the normalized power. The root lies in
  // [2^31, 2^32), so the mantissa in Q0.30 is simply its top 30 bits.
  // ---------------------------------------------------------------------------
  logic               sq_vld;
  logic [31:0]        sq_root;
  sbdn_pkg::sq_side_t sq_side;

  sbdn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v6_r),
    .in_rad   (rad6_r),
    .in_side  (side6_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // ---------------------------------------------------------------------------
  // Stages 39 to 47: cubic polynomial in Horner form, three stages per step.
  //   a: product y*f split into two 36x16 partial products,
  //   b: partial products summed with the half-up rounding offset,
  //   c: arithmetic shift by 30 and the next coefficient added.
  // The first step multiplies the leading coefficient itself.
  // ---------------------------------------------------------------------------
  logic                  va_r    [sbdn_pkg::HORNER_STEPS];
  logic                  vb_r    [sbdn_pkg::HORNER_STEPS];
  logic                  vc_r    [sbdn_pkg::HORNER_STEPS];
  logic signed [51:0]    pa_hi_r [sbdn_pkg::HORNER_STEPS];
  logic signed [51:0]    pa_lo_r [sbdn_pkg::HORNER_STEPS];
  logic signed [67:0]    hsum_r  [sbdn_pkg::HORNER_STEPS];
  logic signed [35:0]    hy_r    [sbdn_pkg::HORNER_STEPS];
  sbdn_pkg::hz_tag_t     ta_r    [sbdn_pkg::HORNER_STEPS];
  sbdn_pkg::hz_tag_t     tb_r    [sbdn_pkg::HORNER_STEPS];
  sbdn_pkg::hz_tag_t     tc_r    [sbdn_pkg::HORNER_STEPS];

  for (genvar h = 0; h < sbdn_pkg::HORNER_STEPS; h++) begin : g_horner
    logic signed [35:0] y_in;
    sbdn_pkg::hz_tag_t  t_in;
    logic               v_in;

    if (h == 0) begin : g_first
      assign y_in = sbdn_pkg::COEF3;
      assign t_in = '{is_zero: sq_side.is_zero, expo: sq_side.expo, f: sq_root[31:2]};
      assign v_in = sq_vld;
    end else begin : g_next
      assign y_in = hy_r[h-1];
      assign t_in = tc_r[h-1];
      assign v_in = vc_r[h-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[h] <= 1'b0;
        vb_r[h] <= 1'b0;
        vc_r[h] <= 1'b0;
      end else if (en) begin
        va_r[h] <= v_in;
        vb_r[h] <= va_r[h];
        vc_r[h] <= vb_r[h];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pa_hi_r[h] <= y_in * $signed({1'b0, t_in.f[29:15]});
        pa_lo_r[h] <= y_in * $signed({1'b0, t_in.f[14:0]});
        ta_r[h]    <= t_in;
        hsum_r[h]  <= (68'(pa_hi_r[h]) <<< 15) + 68'(pa_lo_r[h]) + sbdn_pkg::RND_Q30;
        tb_r[h]    <= ta_r[h];
        hy_r[h]    <= $signed(hsum_r[h][65:30]) + sbdn_pkg::horner_coef(2'(h));
        tc_r[h]    <= tb_r[h];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 48: log2 value l = y + expo in Q30.
  // Stages 49 and 50: dB = l * 20*log10(2), again as two partial products and
  // a rounded sum; the shift by 46 leaves Q8.8 with a wider integer part.
  // Stage 51: offsets from min_db and the width of the display range.
  // Stage 52: special cases and the dividend num*65535 + den/2.
  // ---------------------------------------------------------------------------
  localparam int HL = sbdn_pkg::HORNER_STEPS - 1;

  logic               vl_r, vda_r, vdb_r, vdc_r, vdd_r;
  logic               zl_r, zda_r, zdb_r, zdc_r;
  logic signed [39:0] l_r;
  logic signed [49:0] dhi_r, dlo_r;
  logic signed [67:0] dsum_r;
  logic signed [20:0] num_r;
  logic signed [16:0] den_r;
  logic [31:0]        dvd_r;
  logic [15:0]        dvs_r;
  sbdn_pkg::div_side_t dsel_r;

  logic signed [19:0] db;
  logic [1:0]         sel_nxt;

  assign db = $signed(dsum_r[65:46]);

  always_comb begin
    priority if (zdc_r || (den_r <= 17'sd0) || (num_r <= 21'sd0)) begin
      sel_nxt = sbdn_pkg::LVL_ZERO;
    end else if (num_r >= 21'(den_r)) begin
      sel_nxt = sbdn_pkg::LVL_FULL;
    end else begin
      sel_nxt = sbdn_pkg::LVL_QUOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r  <= 1'b0;
      vda_r <= 1'b0;
      vdb_r <= 1'b0;
      vdc_r <= 1'b0;
      vdd_r <= 1'b0;
    end else if (en) begin
      vl_r  <= vc_r[HL];
      vda_r <= vl_r;
      vdb_r <= vda_r;
      vdc_r <= vdb_r;
      vdd_r <= vdc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r    <= 40'(hy_r[HL]) + $signed({{3{tc_r[HL].expo[6]}}, tc_r[HL].expo, 30'd0});
      zl_r   <= tc_r[HL].is_zero;
      dhi_r  <= $signed(l_r[39:18]) * sbdn_pkg::DB_PER_LOG2;
      dlo_r  <= $signed({1'b0, l_r[17:0]}) * sbdn_pkg::DB_PER_LOG2;
      zda_r  <= zl_r;
      dsum_r <= (68'(dhi_r) <<< 18) + 68'(dlo_r) + sbdn_pkg::RND_Q46;
      zdb_r  <= zda_r;
      num_r  <= 21'(db) - 21'(min_db_r);
      den_r  <= 17'(max_db_r) - 17'(min_db_r);
      zdc_r  <= zdb_r;
      // Only meaningful when 0 < num < den; other cases are overridden by sel.
      dvd_r      <= {num_r[15:0], 16'd0} - {16'd0, num_r[15:0]} + {17'd0, den_r[15:1]};
      dvs_r      <= den_r[15:0];
      dsel_r.sel <= sel_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 53 to 68: level = dividend / den, 16 quotient bits.
  // ---------------------------------------------------------------------------
  logic                dv_vld;
  logic [15:0]         dv_quot;
  sbdn_pkg::div_side_t dv_side;

  sbdn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vdd_r),
    .in_num   (dvd_r),
    .in_den   (dvs_r),
    .in_side  (dsel_r),
    .out_vld  (dv_vld),
    .out_quot (dv_quot),
    .out_side (dv_side)
  );

  // ---------------------------------------------------------------------------
  // Stage 69: output register with a one-item skid stage. When the sink
  // stalls while an item leaves the pipeline, that item parks in the skid
  // stage and the pipeline freezes until the skid stage drains.
  // ---------------------------------------------------------------------------
  logic [15:0] up_level;
  logic        out_vld_r;
  logic [15:0] out_level_r;
  logic [15:0] skid_level_r;

  always_comb begin
    unique case (dv_side.sel)
      sbdn_pkg::LVL_QUOT: up_level = dv_quot;
      sbdn_pkg::LVL_FULL: up_level = 16'hFFFF;
      default:            up_level = 16'h0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_ch.ready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= dv_vld;
      end
    end else if (dv_vld && en) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_vld_r) begin
      out_level_r <= skid_vld_r ? skid_level_r : up_level;
    end else if (dv_vld && en) begin
      skid_level_r <= up_level;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.level = out_level_r;

endmodule

`default_nettype wire

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The register map has a hole at the top index. Writes to it must leave the
  // three real registers untouched.
  localparam logic [sbdn_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  // Cubic log2 approximation on the mantissa, coefficients in Q30.
  localparam logic signed [127:0] LOG_POLY_C3 = 128'sd1322308669;
  localparam logic signed [127:0] LOG_POLY_C2 = -128'sd4422232720;
  localparam logic signed [127:0] LOG_POLY_C1 = 128'sd6466041204;
  localparam logic signed [127:0] LOG_POLY_C0 = -128'sd3365068760;
  // 20*log10(2) in Q24, the factor from log2 units to decibels.
  localparam logic signed [127:0] DB_PER_OCTAVE_Q24 = 128'sd101008905;
  localparam logic signed [127:0] HALF_Q30 = 128'sd536870912;
  localparam logic signed [127:0] HALF_Q46 = 128'sd35184372088832;
  localparam logic [15:0] LEVEL_FLOOR = 16'd0;
  localparam logic [15:0] LEVEL_FULL = 16'hFFFF;

  // Idle mixes applied phase by phase.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SENDER = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH = 3;

  localparam int RANDOM_PHASES = 8;
  localparam int BINS_PER_PHASE = 182;
  // The final wait covers the pipeline latency with a margin on top.
  localparam int PIPE_LATENCY = 68;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } fft_bin_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [sbdn_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [sbdn_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  sbdn_in_if in_ch();
  sbdn_out_if out_ch();

  spectrum_bin_db_normalizer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the display registers, as the block holds them after reset.
  logic signed [15:0] shadow_min_db = sbdn_pkg::MIN_DB_RST;
  logic signed [15:0] shadow_max_db = sbdn_pkg::MAX_DB_RST;
  logic [4:0] shadow_size_log2 = sbdn_pkg::SIZE_LOG2_RST;

  fft_bin_t pending_bins[$];
  logic [15:0] expected_levels[$];

  // Percent chances that the sender sits out a cycle and that the receiver
  // holds off ready. They are changed only between phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int bins_issued = 0;
  int levels_checked = 0;
  int mismatch_count = 0;
  int settings_used = 1;
  int floor_levels = 0;
  int full_levels = 0;
  int mid_levels = 0;
  bit bin_accepted = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Works out the display level of one bin under the current register values.
  // The magnitude is normalized to a mantissa in [0.5, 1) and an exponent, so
  // that the log needs only the cubic on the mantissa plus the exponent. The
  // division by the transform size just lowers that exponent.
  function automatic logic [15:0] bin_to_level(input logic signed [31:0] re,
                                               input logic signed [31:0] im);
    longint sre;
    longint sim;
    logic [63:0] abs_re;
    logic [63:0] abs_im;
    logic [63:0] power;
    logic [63:0] rest;
    logic [63:0] root;
    logic [63:0] probe;
    int msb_len;
    int shift;
    int expo;
    logic signed [127:0] mant;
    logic signed [127:0] poly;
    logic signed [127:0] log2_q30;
    logic signed [127:0] db_q8;
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] lev;
    sre = re;
    sim = im;
    abs_re = (sre < 0) ? -sre : sre;
    abs_im = (sim < 0) ? -sim : sim;
    power = abs_re * abs_re + abs_im * abs_im;
    // A zero bin has no finite log, and an empty range has no scale.
    if (power == 64'd0) return LEVEL_FLOOR;
    if (shadow_max_db <= shadow_min_db) return LEVEL_FLOOR;

    msb_len = 0;
    while (msb_len < 64 && (power >> msb_len) != 64'd0) msb_len++;
    shift = (64 - msb_len) & ~1;

    // Bitwise integer square root of the normalized power.
    rest = power << shift;
    root = 64'd0;
    probe = 64'd1 << 62;
    while (probe > rest) probe = probe >> 2;
    while (probe != 64'd0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end

    mant = root >> 2;
    expo = 32 - shift / 2 - int'(shadow_size_log2);

    poly = LOG_POLY_C3;
    poly = ((poly * mant + HALF_Q30) >>> 30) + LOG_POLY_C2;
    poly = ((poly * mant + HALF_Q30) >>> 30) + LOG_POLY_C1;
    poly = ((poly * mant + HALF_Q30) >>> 30) + LOG_POLY_C0;
    log2_q30 = expo;
    log2_q30 = poly + (log2_q30 <<< 30);

    db_q8 = (log2_q30 * DB_PER_OCTAVE_Q24 + HALF_Q46) >>> 46;
    num = shadow_min_db;
    num = db_q8 - num;
    den = shadow_max_db;
    den = den - shadow_min_db;
    if (num <= 0) return LEVEL_FLOOR;
    if (num >= den) return LEVEL_FULL;
    lev = (num * 65535 + den / 2) / den;
    if (lev > 65535) return LEVEL_FULL;
    return lev[15:0];
  endfunction

  // One component of a random bin. Most draws pick a random bit length first,
  // so the magnitudes spread evenly in dB instead of piling up near full scale.
  function automatic logic signed [31:0] random_bin_part();
    int nbits;
    logic [31:0] mag;
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(4))
          0: return 32'sd0;
          1: return 32'sd1;
          2: return -32'sd1;
          3: return 32'sh7FFFFFFF;
          default: return 32'sh80000000;
        endcase
      end
      default: begin
        nbits = $urandom_range(31);
        mag = $urandom;
        mag = (nbits == 0) ? 32'd0 : mag >> (32 - nbits);
        return $urandom_range(1) ? -$signed(mag) : $signed(mag);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("tb: mismatch at %0t: %s: level %0d, expected %0d", $realtime, what, got,
             want);
    mismatch_count++;
  endtask

  // Driver. A held item stays on the bus until it is taken; after that the
  // next one goes out unless the sender decides to sit this cycle out.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || bin_accepted) begin
      if (pending_bins.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.bin_re <= pending_bins[0].re;
        in_ch.bin_im <= pending_bins[0].im;
        void'(pending_bins.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor. Each accepted bin gets its level predicted on the spot, since the
  // registers cannot change while anything is in flight. Each accepted result
  // is matched against the oldest prediction.
  always @(posedge clk) begin
    bin_accepted = rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1;
    if (bin_accepted) begin
      expected_levels.push_back(bin_to_level(in_ch.bin_re, in_ch.bin_im));
    end
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("result with no bin outstanding", out_ch.level, LEVEL_FLOOR);
      end else begin
        if (out_ch.level !== expected_levels[0]) begin
          report_mismatch("wrong level", out_ch.level, expected_levels[0]);
        end
        void'(expected_levels.pop_front());
      end
      if (out_ch.level == LEVEL_FLOOR) floor_levels++;
      else if (out_ch.level == LEVEL_FULL) full_levels++;
      else mid_levels++;
      levels_checked++;
    end
  end

  task automatic issue_bin(input logic signed [31:0] re, input logic signed [31:0] im);
    fft_bin_t b;
    b.re = re;
    b.im = im;
    pending_bins.push_back(b);
    bins_issued++;
  endtask

  // Every bin yields exactly one level, so once all levels are back the
  // pipeline holds nothing and the registers may be rewritten.
  task automatic settle();
    while (levels_checked != bins_issued) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sbdn_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sbdn_pkg::REG_MIN_DB: shadow_min_db = val;
      sbdn_pkg::REG_MAX_DB: shadow_max_db = val;
      sbdn_pkg::REG_SIZE_LOG2: shadow_size_log2 = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 46;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 46;
      end
      IDLE_BOTH: begin
        send_idle_pct = 34;
        recv_stall_pct = 34;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  initial begin
    int lo_db;
    int hi_db;
    in_ch.valid = 1'b0;
    in_ch.bin_re = '0;
    in_ch.bin_im = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed bins under the reset range of -100 dB to 0 dB with a
    // 1024-point transform: a zero bin, the unit steps, full-scale corners
    // and a few magnitudes that land inside the range, right at its top
    // and just below it.
    set_idle(IDLE_NONE);
    issue_bin(0, 0);
    issue_bin(1, 0);
    issue_bin(0, -1);
    issue_bin(-1, -1);
    issue_bin(3, 4);
    issue_bin(-3, -4);
    issue_bin(1024, 0);
    issue_bin(1023, 0);
    issue_bin(10, 0);
    issue_bin(0, -100);
    issue_bin(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    issue_bin(32'sh80000000, 32'sh80000000);
    issue_bin(32'sh80000000, 0);
    issue_bin(0, 32'sh7FFFFFFF);
    issue_bin(32'sh7FFFFFFF, 32'sh80000000);
    issue_bin(32'sh55555555, 32'shAAAAAAAA);
    settle();

    // Empty range: min and max equal, so every level must sit at the floor.
    write_reg(sbdn_pkg::REG_MIN_DB, 16'h0A00);
    write_reg(sbdn_pkg::REG_MAX_DB, 16'h0A00);
    issue_bin(1000, 0);
    issue_bin(32'sh7FFFFFFF, 0);
    settle();
    // Inverted range behaves the same way.
    write_reg(sbdn_pkg::REG_MIN_DB, 16'h0100);
    write_reg(sbdn_pkg::REG_MAX_DB, 16'hFF00);
    issue_bin(1, 1);
    settle();
    // Widest possible range, with transform sizes outside the usual span.
    write_reg(sbdn_pkg::REG_MIN_DB, 16'h8000);
    write_reg(sbdn_pkg::REG_MAX_DB, 16'h7FFF);
    write_reg(sbdn_pkg::REG_SIZE_LOG2, 16'd0);
    issue_bin(1, 0);
    issue_bin(32'sh7FFFFFFF, 32'sh80000000);
    settle();
    write_reg(sbdn_pkg::REG_SIZE_LOG2, 16'd31);
    issue_bin(1, 0);
    issue_bin(32'sh80000000, 32'sh80000000);
    settle();
    // A write to the unused index must not disturb anything.
    write_reg(REG_UNUSED, 16'hFFFF);
    issue_bin(12345, -678);
    issue_bin(-40000, 3);
    settle();
    settings_used += 5;

    // Random phases. Each picks a fresh range and transform size and cycles
    // through the idle mixes. The first two pin the size to 1 and 16, the ends of its
    // usual span, one throws fully random register bits at the range, and one lets
    // the size take any five-bit value.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p == 3) begin
        write_reg(sbdn_pkg::REG_MIN_DB, 16'($urandom));
        write_reg(sbdn_pkg::REG_MAX_DB, 16'($urandom));
      end else begin
        lo_db = int'($urandom_range(46080)) - 30720;
        hi_db = lo_db + int'($urandom_range(25600, 256));
        if (hi_db > 32767) hi_db = 32767;
        write_reg(sbdn_pkg::REG_MIN_DB, lo_db[15:0]);
        write_reg(sbdn_pkg::REG_MAX_DB, hi_db[15:0]);
      end
      if (p == 0) write_reg(sbdn_pkg::REG_SIZE_LOG2, 16'd1);
      else if (p == 1) write_reg(sbdn_pkg::REG_SIZE_LOG2, 16'd16);
      else if (p == 5) write_reg(sbdn_pkg::REG_SIZE_LOG2, 16'($urandom_range(31)));
      else write_reg(sbdn_pkg::REG_SIZE_LOG2, 16'($urandom_range(16, 1)));
      settings_used++;
      set_idle(p % 4);
      for (int n = 0; n < BINS_PER_PHASE; n++) issue_bin(random_bin_part(), random_bin_part());
    end

    settle();
    repeat (PIPE_LATENCY + 20) @(posedge clk);
    $display("tb: %0d bins checked under %0d register settings, %0d mismatches",
             levels_checked, settings_used, mismatch_count);
    $display("tb: levels at floor %0d, at full scale %0d, in between %0d",
             floor_levels, full_levels, mid_levels);
    if (mismatch_count == 0 && expected_levels.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Guard against a hung pipeline: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb: timeout with %0d of %0d levels back", levels_checked, bins_issued);
    $display("tb: done, errors");
    $finish;
  end

endmodule
